// File: design/smed_pkg.sv
// Package for the three-axis sliding median filter.
// Holds the sample width, the default window length and the sample type.
// No dependencies.
`default_nettype none

package smed_pkg;

	localparam int DATA_W         = 20;
	localparam int WINDOW_DEFAULT = 8;

	typedef logic signed [DATA_W-1:0] sample_t;

endpackage

`default_nettype wire

// File: design/smed_sample_if.sv
// Valid/ready channel that carries one three-axis input sample.
// Depends on smed_pkg for the sample type.
`default_nettype none

interface smed_sample_if;

	logic            valid;
	logic            ready;
	smed_pkg::sample_t sample_x;
	smed_pkg::sample_t sample_y;
	smed_pkg::sample_t sample_z;

	modport source (output valid, output sample_x, output sample_y, output sample_z,
		input ready);
	modport sink (input valid, input sample_x, input sample_y, input sample_z,
		output ready);

endinterface

`default_nettype wire

// File: design/smed_result_if.sv
// Valid/ready channel that carries one filtered three-axis result.
// Depends on smed_pkg for the sample type.
`default_nettype none

interface smed_result_if;

	logic            valid;
	logic            ready;
	smed_pkg::sample_t median_x;
	smed_pkg::sample_t median_y;
	smed_pkg::sample_t median_z;
	logic            filtered;

	modport source (output valid, output median_x, output median_y, output median_z,
		output filtered, input ready);
	modport sink (input valid, input median_x, input median_y, input median_z,
		input filtered, output ready);

endinterface

`default_nettype wire

// File: design/three_axis_sliding_median_core.sv
// Three-axis sliding-window median filter: one transaction in, one transaction out.
// A sample and the ranks from the compare in each cell are written into the window cells
// when it is accepted; the median select then feeds the output register when free.
// Throughput: one sample per cycle while the output is not stalled.
// Reset clears the windows to zero with ranks by position, the fill count and all valids.
`default_nettype none

module three_axis_sliding_median_core #(
	parameter int WINDOW = smed_pkg::WINDOW_DEFAULT
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	smed_sample_if.sink   samples,
	smed_result_if.source results
);

	localparam int FILL_W = $clog2(WINDOW + 1);

	logic              pending_s1;
	logic              full_s1;
	logic [FILL_W-1:0] fill_q;
	logic              out_valid_q;
	smed_pkg::sample_t median_x_q;
	smed_pkg::sample_t median_y_q;
	smed_pkg::sample_t median_z_q;
	logic              filtered_q;

	logic              in_take;
	logic              out_load;
	smed_pkg::sample_t med_x;
	smed_pkg::sample_t med_y;
	smed_pkg::sample_t med_z;
	smed_pkg::sample_t new_x;
	smed_pkg::sample_t new_y;
	smed_pkg::sample_t new_z;

	assign out_load       = pending_s1 && (!out_valid_q || results.ready);
	assign samples.ready  = !pending_s1 || out_load;
	assign in_take        = samples.valid && samples.ready;

	smed_axis_chain #(.WINDOW(WINDOW)) u_chain_x (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (in_take),
		.sample(samples.sample_x),
		.median(med_x),
		.newest(new_x)
	);

	smed_axis_chain #(.WINDOW(WINDOW)) u_chain_y (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (in_take),
		.sample(samples.sample_y),
		.median(med_y),
		.newest(new_y)
	);

	smed_axis_chain #(.WINDOW(WINDOW)) u_chain_z (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (in_take),
		.sample(samples.sample_z),
		.median(med_z),
		.newest(new_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_s1 <= 1'b0;
			full_s1    <= 1'b0;
			fill_q     <= '0;
		end else begin
			if (in_take) begin
				pending_s1 <= 1'b1;
				full_s1    <= (fill_q >= FILL_W'(WINDOW - 1));
				if (fill_q != FILL_W'(WINDOW)) begin
					fill_q <= fill_q + 1'b1;
				end
			end else if (out_load) begin
				pending_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			median_x_q <= full_s1 ? med_x : new_x;
			median_y_q <= full_s1 ? med_y : new_y;
			median_z_q <= full_s1 ? med_z : new_z;
			filtered_q <= full_s1;
		end
	end

	assign results.valid    = out_valid_q;
	assign results.median_x = median_x_q;
	assign results.median_y = median_y_q;
	assign results.median_z = median_z_q;
	assign results.filtered = filtered_q;

endmodule

`default_nettype wire

// File: design/smed_cell.sv
// One window entry of one axis: the stored sample and its rank in the window.
// The rank is updated against the broadcast oldest and newest samples on each shift.
// Depends on smed_pkg.
`default_nettype none

module smed_cell #(
	parameter int RANK_W     = 3,
	parameter int RESET_RANK = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire smed_pkg::sample_t val_in,
	input  wire logic [RANK_W-1:0] rank_in,
	input  wire smed_pkg::sample_t oldest,
	input  wire smed_pkg::sample_t newest,
	output smed_pkg::sample_t      val,
	output logic [RANK_W-1:0]      rank,
	output logic [RANK_W-1:0]      rank_adj,
	output logic                   le_new
);

	smed_pkg::sample_t   val_q;
	logic [RANK_W-1:0]   rank_q;
	logic                le_old;
	logic                lt_new;

	// Ties are broken by age, so the departing oldest entry ranks below any equal entry
	// and the arriving newest entry ranks above it.
	always_comb begin
		le_old   = (oldest <= val_q);
		lt_new   = (newest < val_q);
		le_new   = (val_q <= newest);
		rank_adj = rank_q - RANK_W'(le_old) + RANK_W'(lt_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q  <= '0;
			rank_q <= RANK_W'(RESET_RANK);
		end else if (shift) begin
			val_q  <= val_in;
			rank_q <= rank_in;
		end
	end

	assign val  = val_q;
	assign rank = rank_q;

endmodule

`default_nettype wire

// File: design/smed_axis_chain.sv
// Row of window cells for one axis, with the rank count of the arriving sample
// and the selection of the entry of median rank. Depends on smed_pkg and smed_cell.
`default_nettype none

module smed_axis_chain #(
	parameter int WINDOW = smed_pkg::WINDOW_DEFAULT
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              shift,
	input  wire smed_pkg::sample_t sample,
	output smed_pkg::sample_t      median,
	output smed_pkg::sample_t      newest
);

	localparam int RANK_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int MED_RANK = WINDOW / 2 - 1;

	smed_pkg::sample_t   val_a  [WINDOW];
	logic [RANK_W-1:0]   rank_a [WINDOW];
	logic [RANK_W-1:0]   adj_a  [WINDOW];
	logic [WINDOW-1:0]   le_new_a;
	logic [RANK_W-1:0]   new_rank;
	smed_pkg::sample_t   median_c;

	for (genvar k = 0; k < WINDOW; k++) begin : g_cell
		if (k == WINDOW - 1) begin : g_last
			smed_cell #(.RANK_W(RANK_W), .RESET_RANK(k)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.val_in  (sample),
				.rank_in (new_rank),
				.oldest  (val_a[0]),
				.newest  (sample),
				.val     (val_a[k]),
				.rank    (rank_a[k]),
				.rank_adj(adj_a[k]),
				.le_new  (le_new_a[k])
			);
		end else begin : g_mid
			smed_cell #(.RANK_W(RANK_W), .RESET_RANK(k)) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.shift   (shift),
				.val_in  (val_a[k+1]),
				.rank_in (adj_a[k+1]),
				.oldest  (val_a[0]),
				.newest  (sample),
				.val     (val_a[k]),
				.rank    (rank_a[k]),
				.rank_adj(adj_a[k]),
				.le_new  (le_new_a[k])
			);
		end
	end

	// The arriving sample ranks above every remaining entry that is not greater than it.
	// The departing oldest entry is taken back out of the count.
	always_comb begin
		logic [RANK_W:0] cnt;
		cnt = '0;
		for (int k = 0; k < WINDOW; k++) begin
			cnt = cnt + (RANK_W+1)'(le_new_a[k]);
		end
		cnt      = cnt - (RANK_W+1)'(le_new_a[0]);
		new_rank = cnt[RANK_W-1:0];
	end

	// Ranks are a permutation of the window positions, so exactly one entry matches.
	always_comb begin
		median_c = '0;
		for (int k = 0; k < WINDOW; k++) begin
			if (rank_a[k] == RANK_W'(MED_RANK)) begin
				median_c = median_c | val_a[k];
			end
		end
	end

	assign median = median_c;
	assign newest = val_a[WINDOW-1];

endmodule

`default_nettype wire

// File: design/smed_checker.sv
// Port-level checker for the sliding median core, bound to the top level.
// Depends on smed_pkg; sees only the handshake and payload ports of the core.
`default_nettype none

module smed_checker #(
	parameter int WINDOW = smed_pkg::WINDOW_DEFAULT
) (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire smed_pkg::sample_t median_x,
	input wire logic              filtered
);

	localparam int CNT_W = $clog2(WINDOW + 1);

	logic             in_acc;
	logic             out_acc;
	logic [1:0]       inflight_q;
	logic [CNT_W-1:0] out_cnt_q;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			out_cnt_q  <= '0;
		end else begin
			inflight_q <= inflight_q + 2'(in_acc) - 2'(out_acc);
			if (out_acc && out_cnt_q != CNT_W'(WINDOW)) begin
				out_cnt_q <= out_cnt_q + 1'b1;
			end
		end
	end

	// A result transaction never appears without an accepted sample behind it.
	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (inflight_q != 2'd0))
		else $error("result valid with no sample outstanding");

	// The core holds at most two samples between input and output.
	a_depth: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> (inflight_q != 2'd2) || out_acc)
		else $error("sample accepted beyond pipeline depth");

	// The filtered flag is low during warm-up and high once the window is full.
	a_warmup: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc |-> (filtered == (out_cnt_q >= CNT_W'(WINDOW - 1))))
		else $error("filtered flag does not follow the window fill");

	// A stalled result keeps its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(median_x) && $stable(filtered))
		else $error("stalled result changed");

endmodule

bind three_axis_sliding_median_core smed_checker #(.WINDOW(WINDOW)) u_smed_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_valid (samples.valid),
	.in_ready (samples.ready),
	.out_valid(results.valid),
	.out_ready(results.ready),
	.median_x (results.median_x),
	.filtered (results.filtered)
);

`default_nettype wire
